// File: hdl/polygon_line_crossing_counter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polygon line crossing counter
// Concurrent checks, sampled on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POLYGON_LINE_CROSSING_COUNTER_ASSERT_SVH
`define POLYGON_LINE_CROSSING_COUNTER_ASSERT_SVH

// property that must hold at every edge
`define PLCC_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication within the same cycle
`define PLCC_ASSERT_IMP(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

// File: hdl/plcc_pkg.sv
// ----------------------------------------------------------------------------
// plcc_pkg
// Shared widths, register indexes and payload types of the crossing counter.
// ----------------------------------------------------------------------------
package plcc_pkg;

   localparam int COORD_BITS = 24;
   localparam int COUNT_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int TOL_BITS   = 2 * COORD_BITS + 1;

   // job queue, depth must be a power of two
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;

   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   localparam logic [2:0] REG_ORIGIN_X       = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y       = 3'd1;
   localparam logic [2:0] REG_DIRECTION_X    = 3'd2;
   localparam logic [2:0] REG_DIRECTION_Y    = 3'd3;
   localparam logic [2:0] REG_NULL_TOLERANCE = 3'd4;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic                         last_vertex;
   } vertex_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count_forward;
      logic [COUNT_BITS-1:0] count_backward;
      logic                  border_hit;
   } result_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   // one vertex triple to judge; finish closes the polygon
   typedef struct packed {
      point_type prev;
      point_type mid;
      point_type next;
      logic      finish;
   } job_type;

   typedef struct packed {
      logic [FIFO_CW-1:0] fill;
      logic               full;
      logic               empty;
   } fifo_status_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic signed [COORD_BITS-1:0] direction_x;
      logic signed [COORD_BITS-1:0] direction_y;
      logic [TOL_BITS-1:0]          null_tolerance;
   } config_type;

   typedef struct packed {
      logic vld;
      logic finish;
      logic border;
      logic fwd;
      logic bwd;
   } verdict_type;

endpackage

// File: hdl/polygon_line_crossing_counter.sv
// ----------------------------------------------------------------------------
// polygon_line_crossing_counter
// Throughput: one vertex per cycle while the job queue has room; the last vertex
// of a polygon with two or more vertices holds off the next vertex while the two
// wraparound triples are issued. Reset is synchronous: clears control and tallies,
// loads register defaults.
// ----------------------------------------------------------------------------
`include "polygon_line_crossing_counter_assert.svh"

module polygon_line_crossing_counter import plcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vertex_type        req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output result_type        rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   config_type      cfg_ff, cfg_in;
   logic [2:0]      reg_index;
   logic            csr_write;
   logic            push_valid;
   job_type         push_data;
   job_type         head;
   fifo_status_type fifo_status;
   logic            pop;
   logic            hold;
   verdict_type     verdict;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_AW-1:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_ORIGIN_X:       cfg_in.origin_x       = csr_pwdata[COORD_BITS-1:0];
            REG_ORIGIN_Y:       cfg_in.origin_y       = csr_pwdata[COORD_BITS-1:0];
            REG_DIRECTION_X:    cfg_in.direction_x    = csr_pwdata[COORD_BITS-1:0];
            REG_DIRECTION_Y:    cfg_in.direction_y    = csr_pwdata[COORD_BITS-1:0];
            REG_NULL_TOLERANCE: cfg_in.null_tolerance = csr_pwdata[TOL_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ORIGIN_X:       csr_prdata = {{(CSR_DW-COORD_BITS){1'b0}}, cfg_ff.origin_x};
         REG_ORIGIN_Y:       csr_prdata = {{(CSR_DW-COORD_BITS){1'b0}}, cfg_ff.origin_y};
         REG_DIRECTION_X:    csr_prdata = {{(CSR_DW-COORD_BITS){1'b0}}, cfg_ff.direction_x};
         REG_DIRECTION_Y:    csr_prdata = {{(CSR_DW-COORD_BITS){1'b0}}, cfg_ff.direction_y};
         REG_NULL_TOLERANCE: csr_prdata = {{(CSR_DW-TOL_BITS){1'b0}}, cfg_ff.null_tolerance};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x       <= '0;
         cfg_ff.origin_y       <= '0;
         cfg_ff.direction_x    <= COORD_BITS'(1);
         cfg_ff.direction_y    <= '0;
         cfg_ff.null_tolerance <= TOL_BITS'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   plcc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   plcc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .status     (fifo_status),
      .head       (head)
   );

   plcc_judge u_judge (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (!fifo_status.empty),
      .head       (head),
      .hold       (hold),
      .pop        (pop),
      .verdict    (verdict)
   );

   plcc_tally u_tally (
      .clock     (clock),
      .reset     (reset),
      .verdict   (verdict),
      .hold      (hold),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `PLCC_ASSERT_ALWAYS(a_fifo_bound, fifo_status.fill <= FIFO_CW'(FIFO_DEPTH), "job queue overfilled")
   `PLCC_ASSERT_IMP(a_result_source, $rose(rsp_valid), $past(verdict.vld && verdict.finish), "result without closing item")
   `PLCC_ASSERT_IMP(a_border_parity, rsp_valid && rsp_data.border_hit && (rsp_data.count_forward != '0 || rsp_data.count_backward != '0), rsp_data.count_forward[0], "border fix left forward count even")

endmodule

// File: hdl/plcc_front.sv
// ----------------------------------------------------------------------------
// plcc_front
// Takes vertices, keeps the neighbour history and issues triples to judge.
// ----------------------------------------------------------------------------
module plcc_front import plcc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  vertex_type      req_data,
   input  fifo_status_type fifo_status,
   output logic            push_valid,
   output job_type         push_data
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_WRAP_A = 2'd1;
   localparam logic [1:0] PH_WRAP_B = 2'd2;

   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_MANY = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [1:0] seen_ff, seen_in;
   point_type  first_ff, first_in;
   point_type  second_ff, second_in;
   point_type  older_ff, older_in;
   point_type  recent_ff, recent_in;
   point_type  tail_ff, tail_in;
   point_type  new_pt;
   logic       accept;

   assign req_ready = (phase_ff == PH_IDLE) && !fifo_status.full;
   assign accept    = req_valid && req_ready;
   assign new_pt    = '{x: req_data.vertex_x, y: req_data.vertex_y};

   always_comb begin
      phase_in   = phase_ff;
      seen_in    = seen_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      older_in   = older_ff;
      recent_in  = recent_ff;
      tail_in    = tail_ff;
      push_valid = 1'b0;
      push_data  = '{prev: older_ff, mid: recent_ff, next: new_pt, finish: 1'b0};
      unique case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               if (seen_ff == SEEN_MANY) begin
                  push_valid = 1'b1;
               end else if (req_data.last_vertex && seen_ff == SEEN_NONE) begin
                  // lone vertex: judged against itself
                  push_valid = 1'b1;
                  push_data  = '{prev: new_pt, mid: new_pt, next: new_pt, finish: 1'b1};
               end
               if (seen_ff == SEEN_NONE) first_in = new_pt;
               if (seen_ff == SEEN_ONE) second_in = new_pt;
               if (req_data.last_vertex) begin
                  tail_in = new_pt;
                  if (seen_ff != SEEN_NONE) phase_in = PH_WRAP_A;
               end else begin
                  older_in  = recent_ff;
                  recent_in = new_pt;
                  if (seen_ff != SEEN_MANY) seen_in = seen_ff + 2'd1;
               end
            end
         end
         PH_WRAP_A: begin
            if (!fifo_status.full) begin
               push_valid = 1'b1;
               push_data  = '{prev: recent_ff, mid: tail_ff, next: first_ff, finish: 1'b0};
               phase_in   = PH_WRAP_B;
            end
         end
         PH_WRAP_B: begin
            if (!fifo_status.full) begin
               push_valid = 1'b1;
               push_data  = '{prev: tail_ff, mid: first_ff, next: second_ff, finish: 1'b1};
               phase_in   = PH_IDLE;
               seen_in    = SEEN_NONE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         seen_ff  <= SEEN_NONE;
      end else begin
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
      older_ff  <= older_in;
      recent_ff <= recent_in;
      tail_ff   <= tail_in;
   end

endmodule

// File: hdl/plcc_fifo.sv
// ----------------------------------------------------------------------------
// plcc_fifo
// Short job queue between the vertex front end and the judging pipeline.
// ----------------------------------------------------------------------------
module plcc_fifo import plcc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  job_type         push_data,
   input  logic            pop,
   output fifo_status_type status,
   output job_type         head
);

   job_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0] fill_ff, fill_in;
   logic               push_ok, pop_ok;

   assign status.fill  = fill_ff;
   assign status.full  = (fill_ff == FIFO_CW'(FIFO_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   assign push_ok = push_valid && !status.full;
   assign pop_ok  = pop && !status.empty;

   always_comb begin
      unique case ({push_ok, pop_ok})
         2'b10:   fill_in = fill_ff + FIFO_CW'(1);
         2'b01:   fill_in = fill_ff - FIFO_CW'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push_ok) wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         if (pop_ok) rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: hdl/plcc_judge.sv
// ----------------------------------------------------------------------------
// plcc_judge
// Four stage pipeline: origin offset, products, cross/dot sums, verdict.
// ----------------------------------------------------------------------------
module plcc_judge import plcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  config_type  cfg,
   input  logic        head_valid,
   input  job_type     head,
   input  logic        hold,
   output logic        pop,
   output verdict_type verdict
);

   localparam int P0X = 0;
   localparam int P0Y = 1;
   localparam int P1X = 2;
   localparam int P1Y = 3;
   localparam int P2X = 4;
   localparam int P2Y = 5;

   localparam int SUM_X01 = 0;
   localparam int SUM_X12 = 1;
   localparam int SUM_C0  = 2;
   localparam int SUM_C1  = 3;
   localparam int SUM_C2  = 4;
   localparam int SUM_D1  = 5;
   localparam int SUM_D2  = 6;

   logic signed [DIFF_BITS-1:0] diff_ff [6];
   logic signed [DIFF_BITS-1:0] diff_in [6];
   logic signed [PROD_BITS-1:0] prod_ff [14];
   logic signed [PROD_BITS-1:0] prod_in [14];
   logic signed [SUM_BITS-1:0]  sum_ff [7];
   logic signed [SUM_BITS-1:0]  sum_in [7];
   logic signed [DIFF_BITS-1:0] dir_x, dir_y;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic s1_fin_ff, s2_fin_ff, s3_fin_ff;
   verdict_type verdict_ff, verdict_in;
   logic advance;
   logic nul_x01, nul_x12, nul_c1;
   logic c0_neg, c0_pos, c1_neg, c1_pos, c2_neg, c2_pos, d1_pos, d2_pos;
   logic opp_a, opp_t, hit;

   function automatic logic signed [DIFF_BITS-1:0] offset(
      input logic signed [COORD_BITS-1:0] v,
      input logic signed [COORD_BITS-1:0] o
   );
      return DIFF_BITS'(v) - DIFF_BITS'(o);
   endfunction

   function automatic logic is_null(
      input logic signed [SUM_BITS-1:0] v,
      input logic [TOL_BITS-1:0]        tol
   );
      logic [SUM_BITS-1:0] mag;
      mag = v[SUM_BITS-1] ? SUM_BITS'(-v) : SUM_BITS'(v);
      return mag < SUM_BITS'(tol);
   endfunction

   assign advance = !hold;
   assign pop     = head_valid && advance;
   assign verdict = verdict_ff;
   assign dir_x   = DIFF_BITS'(cfg.direction_x);
   assign dir_y   = DIFF_BITS'(cfg.direction_y);

   always_comb begin
      diff_in[P0X] = offset(head.prev.x, cfg.origin_x);
      diff_in[P0Y] = offset(head.prev.y, cfg.origin_y);
      diff_in[P1X] = offset(head.mid.x, cfg.origin_x);
      diff_in[P1Y] = offset(head.mid.y, cfg.origin_y);
      diff_in[P2X] = offset(head.next.x, cfg.origin_x);
      diff_in[P2Y] = offset(head.next.y, cfg.origin_y);
   end

   always_comb begin
      prod_in[0]  = diff_ff[P0X] * diff_ff[P1Y];
      prod_in[1]  = diff_ff[P0Y] * diff_ff[P1X];
      prod_in[2]  = diff_ff[P1X] * diff_ff[P2Y];
      prod_in[3]  = diff_ff[P1Y] * diff_ff[P2X];
      prod_in[4]  = diff_ff[P0X] * dir_y;
      prod_in[5]  = diff_ff[P0Y] * dir_x;
      prod_in[6]  = diff_ff[P1X] * dir_y;
      prod_in[7]  = diff_ff[P1Y] * dir_x;
      prod_in[8]  = diff_ff[P2X] * dir_y;
      prod_in[9]  = diff_ff[P2Y] * dir_x;
      prod_in[10] = diff_ff[P1X] * dir_x;
      prod_in[11] = diff_ff[P1Y] * dir_y;
      prod_in[12] = diff_ff[P2X] * dir_x;
      prod_in[13] = diff_ff[P2Y] * dir_y;
   end

   always_comb begin
      sum_in[SUM_X01] = SUM_BITS'(prod_ff[0]) - SUM_BITS'(prod_ff[1]);
      sum_in[SUM_X12] = SUM_BITS'(prod_ff[2]) - SUM_BITS'(prod_ff[3]);
      sum_in[SUM_C0]  = SUM_BITS'(prod_ff[4]) - SUM_BITS'(prod_ff[5]);
      sum_in[SUM_C1]  = SUM_BITS'(prod_ff[6]) - SUM_BITS'(prod_ff[7]);
      sum_in[SUM_C2]  = SUM_BITS'(prod_ff[8]) - SUM_BITS'(prod_ff[9]);
      sum_in[SUM_D1]  = SUM_BITS'(prod_ff[10]) + SUM_BITS'(prod_ff[11]);
      sum_in[SUM_D2]  = SUM_BITS'(prod_ff[12]) + SUM_BITS'(prod_ff[13]);
   end

   always_comb begin
      nul_x01 = is_null(sum_ff[SUM_X01], cfg.null_tolerance);
      nul_x12 = is_null(sum_ff[SUM_X12], cfg.null_tolerance);
      nul_c1  = is_null(sum_ff[SUM_C1], cfg.null_tolerance);
      c0_neg  = sum_ff[SUM_C0][SUM_BITS-1];
      c0_pos  = !c0_neg && (sum_ff[SUM_C0] != '0);
      c1_neg  = sum_ff[SUM_C1][SUM_BITS-1];
      c1_pos  = !c1_neg && (sum_ff[SUM_C1] != '0);
      c2_neg  = sum_ff[SUM_C2][SUM_BITS-1];
      c2_pos  = !c2_neg && (sum_ff[SUM_C2] != '0);
      d1_pos  = !sum_ff[SUM_D1][SUM_BITS-1] && (sum_ff[SUM_D1] != '0);
      d2_pos  = !sum_ff[SUM_D2][SUM_BITS-1] && (sum_ff[SUM_D2] != '0);
      // strict sign change, or a vertex touching the line between opposite sides
      opp_a   = (c1_pos && c2_neg) || (c1_neg && c2_pos);
      opp_t   = nul_c1 && ((c0_pos && c2_neg) || (c0_neg && c2_pos));

      verdict_in.vld    = s3_vld_ff;
      verdict_in.finish = s3_fin_ff;
      verdict_in.border = nul_x01 || nul_x12;
      hit               = !verdict_in.border && (opp_a || opp_t);
      verdict_in.fwd    = hit && ((opp_a && (d1_pos || d2_pos)) || (opp_t && d1_pos));
      verdict_in.bwd    = hit && !verdict_in.fwd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         verdict_ff <= '0;
      end else if (advance) begin
         s1_vld_ff  <= head_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         verdict_ff <= verdict_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff   <= diff_in;
         prod_ff   <= prod_in;
         sum_ff    <= sum_in;
         s1_fin_ff <= head.finish;
         s2_fin_ff <= s1_fin_ff;
         s3_fin_ff <= s2_fin_ff;
      end
   end

endmodule

// File: hdl/plcc_tally.sv
// ----------------------------------------------------------------------------
// plcc_tally
// Crossing tallies, border parity fix and the result register.
// ----------------------------------------------------------------------------
module plcc_tally import plcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  verdict_type verdict,
   output logic        hold,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output result_type  rsp_data
);

   logic [COUNT_BITS-1:0] fwd_ff, fwd_in, bwd_ff, bwd_in, fwd_sum, bwd_sum;
   logic                  border_ff, border_in, border_sum;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff, result;
   logic                  take, load;

   // a closing item waits only while the result register is still full and rsp_ready is low
   assign hold      = verdict.vld && verdict.finish && rsp_valid_ff && !rsp_ready;
   assign take      = verdict.vld && !hold;
   assign load      = take && verdict.finish;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      fwd_sum    = (verdict.fwd && fwd_ff != COUNT_MAX) ? fwd_ff + COUNT_BITS'(1) : fwd_ff;
      bwd_sum    = (verdict.bwd && bwd_ff != COUNT_MAX) ? bwd_ff + COUNT_BITS'(1) : bwd_ff;
      border_sum = border_ff || verdict.border;

      result.count_forward  = fwd_sum;
      result.count_backward = bwd_sum;
      result.border_hit     = border_sum;
      // making an even count odd is just setting bit 0
      if (border_sum && (fwd_sum != '0 || bwd_sum != '0)) begin
         priority if (!fwd_sum[0]) begin
            result.count_forward[0] = 1'b1;
         end else if (!bwd_sum[0]) begin
            result.count_backward[0] = 1'b1;
         end else begin
            // both counts already odd
         end
      end

      fwd_in    = fwd_ff;
      bwd_in    = bwd_ff;
      border_in = border_ff;
      if (take) begin
         if (verdict.finish) begin
            fwd_in    = '0;
            bwd_in    = '0;
            border_in = 1'b0;
         end else begin
            fwd_in    = fwd_sum;
            bwd_in    = bwd_sum;
            border_in = border_sum;
         end
      end

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff       <= '0;
         bwd_ff       <= '0;
         border_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fwd_ff       <= fwd_in;
         bwd_ff       <= bwd_in;
         border_ff    <= border_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_data_ff <= result;
   end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Crossing counter testbench
// Streams polygons through the block, predicts the crossing counts and the
// border flag of every closed polygon, and checks each result item as it
// leaves. Register settings change between phases, with random idling on
// both channels.
// ----------------------------------------------------------------------------
import plcc_pkg::*;

class crossing_scoreboard;
   localparam int SEEN_LIMIT = 131071;

   longint origin_x, origin_y, dir_x, dir_y, tolerance;
   longint first_x, first_y, second_x, second_y;
   longint older_x, older_y, recent_x, recent_y;
   int     seen;
   logic [COUNT_BITS-1:0] fwd_tally, bwd_tally;
   bit     border_seen;
   result_type expected_counts[$];
   int     errors;

   function new();
      errors = 0;
      origin_x = 0;
      origin_y = 0;
      dir_x = 1;
      dir_y = 0;
      tolerance = 1;
      clear_polygon();
   endfunction

   function void report(string msg);
      errors++;
      if (errors <= 100) $display("[tb] mismatch: %s", msg);
   endfunction

   function logic [63:0] field_mask(logic [2:0] idx);
      if (idx == REG_NULL_TOLERANCE) return (64'd1 << TOL_BITS) - 64'd1;
      return (64'd1 << COORD_BITS) - 64'd1;
   endfunction

   function void set_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
         REG_ORIGIN_X:       origin_x = longint'($signed(value[COORD_BITS-1:0]));
         REG_ORIGIN_Y:       origin_y = longint'($signed(value[COORD_BITS-1:0]));
         REG_DIRECTION_X:    dir_x = longint'($signed(value[COORD_BITS-1:0]));
         REG_DIRECTION_Y:    dir_y = longint'($signed(value[COORD_BITS-1:0]));
         REG_NULL_TOLERANCE: tolerance = longint'(value & field_mask(idx));
         default: ;
      endcase
   endfunction

   function logic [63:0] reg_value(logic [2:0] idx);
      longint v;
      case (idx)
         REG_ORIGIN_X:    v = origin_x;
         REG_ORIGIN_Y:    v = origin_y;
         REG_DIRECTION_X: v = dir_x;
         REG_DIRECTION_Y: v = dir_y;
         default:         v = tolerance;
      endcase
      return 64'(v) & field_mask(idx);
   endfunction

   function void clear_polygon();
      first_x = 0; first_y = 0; second_x = 0; second_y = 0;
      older_x = 0; older_y = 0; recent_x = 0; recent_y = 0;
      seen = 0;
      fwd_tally = '0;
      bwd_tally = '0;
      border_seen = 0;
   endfunction

   function bit is_null(longint x);
      longint mag;
      mag = (x < 0) ? -x : x;
      return mag < tolerance;
   endfunction

   function bit opposite(longint a, longint b);
      return (a > 0 && b < 0) || (a < 0 && b > 0);
   endfunction

   function void judge_triple(longint ax, longint ay, longint bx, longint by,
                              longint cx, longint cy);
      longint p0x, p0y, p1x, p1y, p2x, p2y, c0, c1, c2, d1, d2;
      bit crossing, touching;
      p0x = ax - origin_x; p0y = ay - origin_y;
      p1x = bx - origin_x; p1y = by - origin_y;
      p2x = cx - origin_x; p2y = cy - origin_y;
      if (is_null(p0x * p1y - p0y * p1x) || is_null(p1x * p2y - p1y * p2x)) begin
         border_seen = 1;
         return;
      end
      c0 = p0x * dir_y - p0y * dir_x;
      c1 = p1x * dir_y - p1y * dir_x;
      c2 = p2x * dir_y - p2y * dir_x;
      d1 = p1x * dir_x + p1y * dir_y;
      d2 = p2x * dir_x + p2y * dir_y;
      crossing = opposite(c1, c2);
      touching = is_null(c1) && opposite(c0, c2);
      if (!crossing && !touching) return;
      if ((crossing && (d1 > 0 || d2 > 0)) || (touching && d1 > 0)) begin
         if (fwd_tally != COUNT_MAX) fwd_tally++;
      end else begin
         if (bwd_tally != COUNT_MAX) bwd_tally++;
      end
   endfunction

   function void note_vertex(vertex_type v);
      longint nx, ny;
      int k;
      result_type r;
      nx = longint'($signed(v.vertex_x));
      ny = longint'($signed(v.vertex_y));
      k = seen;
      if (k >= 2) judge_triple(older_x, older_y, recent_x, recent_y, nx, ny);
      if (k == 0) begin
         first_x = nx; first_y = ny;
      end else if (k == 1) begin
         second_x = nx; second_y = ny;
      end
      if (!v.last_vertex) begin
         older_x = recent_x; older_y = recent_y;
         recent_x = nx; recent_y = ny;
         if (seen < SEEN_LIMIT) seen++;
         return;
      end
      if (k == 0) begin
         judge_triple(nx, ny, nx, ny, nx, ny);
      end else begin
         judge_triple(recent_x, recent_y, nx, ny, first_x, first_y);
         judge_triple(nx, ny, first_x, first_y, second_x, second_y);
      end
      // border fix: make the first even count odd
      if (border_seen && (fwd_tally != 0 || bwd_tally != 0)) begin
         if (!fwd_tally[0]) fwd_tally++;
         else if (!bwd_tally[0]) bwd_tally++;
      end
      r.count_forward = fwd_tally;
      r.count_backward = bwd_tally;
      r.border_hit = border_seen;
      expected_counts.push_back(r);
      clear_polygon();
   endfunction

   function void check_result(result_type got);
      result_type want;
      if (expected_counts.size() == 0) begin
         report("result item with no closed polygon outstanding");
         return;
      end
      want = expected_counts.pop_front();
      if (got.count_forward !== want.count_forward)
         report($sformatf("count_forward %0d, expected %0d",
                          got.count_forward, want.count_forward));
      if (got.count_backward !== want.count_backward)
         report($sformatf("count_backward %0d, expected %0d",
                          got.count_backward, want.count_backward));
      if (got.border_hit !== want.border_hit)
         report($sformatf("border_hit %0b, expected %0b", got.border_hit, want.border_hit));
   endfunction

   function int pending();
      return expected_counts.size();
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 20;
   localparam int ZIGZAG_VERTICES = 100;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   vertex_type        req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   result_type        rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   crossing_scoreboard sb = new();
   bit quiet = 0;
   int cycles = 0;
   int stall_left = 0;
   int calm_left = 0;

   polygon_line_crossing_counter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[polygon_line_crossing_counter] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // result side back-pressure: short stalls, with calm stretches
   always @(negedge clock) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 40) == 0) calm_left = $urandom_range(20, 80);
      if (stall_left == 0 && !quiet && calm_left == 0 && $urandom_range(0, 3) == 0)
         stall_left = $urandom_range(1, 4);
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic vertex_type vertex_at(longint x, longint y, bit last);
      vertex_type v;
      v.vertex_x = COORD_BITS'(x);
      v.vertex_y = COORD_BITS'(y);
      v.last_vertex = last;
      return v;
   endfunction

   // scale 0 means anywhere in the coordinate range, else near the origin
   function automatic vertex_type random_vertex(int scale, bit last);
      if (scale == 0) return vertex_at(longint'($urandom), longint'($urandom), last);
      return vertex_at(sb.origin_x + $urandom_range(0, 2 * scale) - scale,
                       sb.origin_y + $urandom_range(0, 2 * scale) - scale, last);
   endfunction

   task automatic send_vertex(vertex_type v, bit gaps);
      if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= v;
      do @(posedge clock); while (!req_ready);
      sb.note_vertex(v);
      @(negedge clock);
   endtask

   task automatic csr_check(logic [2:0] idx);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 3'b000};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & sb.field_mask(idx)) !== sb.reg_value(idx))
         sb.report($sformatf("register %0d reads %0h, expected %0h",
                             idx, csr_prdata & sb.field_mask(idx), sb.reg_value(idx)));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_check(idx);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(logic [COORD_BITS-1:0] ox, logic [COORD_BITS-1:0] oy,
                                 logic [COORD_BITS-1:0] dx, logic [COORD_BITS-1:0] dy,
                                 logic [TOL_BITS-1:0] tol);
      wait_idle();
      csr_write(REG_ORIGIN_X, 64'(ox));
      csr_write(REG_ORIGIN_Y, 64'(oy));
      csr_write(REG_DIRECTION_X, 64'(dx));
      csr_write(REG_DIRECTION_Y, 64'(dy));
      csr_write(REG_NULL_TOLERANCE, 64'(tol));
   endtask

   task automatic random_polygons(int items);
      int sent, len, scale;
      bit calm;
      sent = 0;
      while (sent < items) begin
         len = $urandom_range(0, 19);
         if (len < 3) len = $urandom_range(1, 2);
         else if (len < 17) len = $urandom_range(3, 8);
         else len = $urandom_range(9, 40);
         case ($urandom_range(0, 9))
            0, 1:    scale = 0;
            2, 3, 4: scale = 2;
            5, 6:    scale = 16;
            7:       scale = 4096;
            8:       scale = 1 << 20;
            default: scale = 1;
         endcase
         calm = ($urandom_range(0, 4) == 0);
         for (int j = 0; j < len; j++) begin
            send_vertex(random_vertex(scale, j == len - 1), !calm);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_check(REG_ORIGIN_X);
      csr_check(REG_ORIGIN_Y);
      csr_check(REG_DIRECTION_X);
      csr_check(REG_DIRECTION_Y);
      csr_check(REG_NULL_TOLERANCE);

      // single vertices, at the origin and at a coordinate corner
      send_vertex(vertex_at(0, 0, 1), 1'b0);
      send_vertex(vertex_at(8388607, -8388608, 1), 1'b0);
      // two vertices, each the other's neighbour on both sides
      send_vertex(vertex_at(-8388608, -8388608, 0), 1'b0);
      send_vertex(vertex_at(8388607, 8388607, 1), 1'b0);
      // square around the origin: one crossing on each side of the origin
      send_vertex(vertex_at(5, 5, 0), 1'b0);
      send_vertex(vertex_at(-5, 5, 0), 1'b0);
      send_vertex(vertex_at(-5, -5, 0), 1'b0);
      send_vertex(vertex_at(5, -5, 1), 1'b0);
      // vertex touching the line, forward then backward
      send_vertex(vertex_at(4, 0, 0), 1'b0);
      send_vertex(vertex_at(-3, 3, 0), 1'b0);
      send_vertex(vertex_at(-3, -3, 1), 1'b0);
      send_vertex(vertex_at(-4, 0, 0), 1'b0);
      send_vertex(vertex_at(3, -3, 0), 1'b0);
      send_vertex(vertex_at(3, 3, 1), 1'b0);
      // edge in line with the origin together with real crossings
      send_vertex(vertex_at(2, 2, 0), 1'b0);
      send_vertex(vertex_at(4, 4, 0), 1'b0);
      send_vertex(vertex_at(-3, 3, 0), 1'b0);
      send_vertex(vertex_at(-3, -3, 0), 1'b0);
      send_vertex(vertex_at(3, -3, 1), 1'b0);

      random_polygons(150);

      apply_settings(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     49'($urandom_range(0, 1 << 24)));
      random_polygons(250);

      apply_settings(24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607, '0);
      random_polygons(250);

      // zero direction with the top tolerance bit set
      apply_settings(-24'sd8388608, 24'sd8388607, '0, '0, 49'd1 << 48);
      random_polygons(150);

      apply_settings(24'($urandom_range(0, 40)) - 24'd20, 24'($urandom_range(0, 40)) - 24'd20,
                     '0, 24'd1, 49'd1);
      random_polygons(250);

      apply_settings('0, '0, 24'sd8388607, 24'sd8388607, 49'd1 << 48);
      random_polygons(150);

      // zigzag polygon crossing the line on every edge, sent with random gaps
      apply_settings('0, '0, 24'd1, '0, 49'd1);
      for (int i = 0; i < ZIGZAG_VERTICES; i++)
         send_vertex(vertex_at(i - ZIGZAG_VERTICES / 2, (i % 2) ? -1 : 1,
                               i == ZIGZAG_VERTICES - 1), 1'b1);

      apply_settings(24'($urandom_range(0, 200)) - 24'd100,
                     24'($urandom_range(0, 200)) - 24'd100,
                     24'($urandom_range(0, 6)) - 24'd3, 24'($urandom_range(0, 6)) - 24'd3,
                     49'($urandom_range(0, 4)));
      quiet = 1;
      random_polygons(300);

      wait_idle();
      if (sb.errors == 0) begin
         $display("[polygon_line_crossing_counter] OK");
      end else begin
         $display("[polygon_line_crossing_counter] ERROR");
      end
      $finish;
   end
endmodule
